FILE: src/rfr_pkg.sv
// Shared types and constants of the clipped rectangle fill rasterizer.
`default_nettype none

package rfr_pkg;

  localparam int SCR_W       = 11;
  localparam int ADDR_W      = 20;
  localparam int COLOR_W     = 8;
  localparam int MODE_W      = 2;
  localparam int MASK_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_TDATA_W = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam int OUT_ADDR_LSB = 0;
  localparam int OUT_DATA_LSB = ADDR_W;
  localparam int OUT_MASK_LSB = ADDR_W + COLOR_W;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TCOLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEN    = 3'd4;

  localparam logic [MODE_W-1:0] PIXEL_MODE_PACKED = 2'd0;
  localparam logic [MODE_W-1:0] PIXEL_MODE_BYTE   = 2'd1;

  localparam logic [MASK_W-1:0] LANE_LOW  = 2'd1;
  localparam logic [MASK_W-1:0] LANE_HIGH = 2'd2;
  localparam logic [MASK_W-1:0] LANE_BOTH = 2'd3;

  localparam logic [COLOR_W-1:0] NIBBLE_LOW  = 8'h0f;
  localparam logic [COLOR_W-1:0] NIBBLE_HIGH = 8'hf0;
  localparam logic [COLOR_W-1:0] BYTE_FULL   = 8'hFF;

  typedef logic [SCR_W-1:0]   coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    coord_t    x_begin;
    coord_t    x_end;
    coord_t    y_begin;
    coord_t    y_end;
    addr_t     row_base;
    color_t    color;
    logic      filled;
  } cmd_t;

  typedef struct packed {
    coord_t              eff_width;
    coord_t              eff_height;
    logic [MODE_W-1:0]   mode;
    color_t              transp_color;
    logic                transp_en;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/rfr_front.sv
// Front end: takes items, clips start rectangles and builds queue commands.
`default_nettype none

module rfr_front import rfr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cfg_t                         cfg_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic signed [COORD_BITS-1:0] origin_x_i,
  input  wire logic signed [COORD_BITS-1:0] origin_y_i,
  input  wire logic signed [COORD_BITS-1:0] size_w_i,
  input  wire logic signed [COORD_BITS-1:0] size_h_i,
  input  wire color_t                       fill_color_i,
  input  wire logic                         filled_i,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output cmd_t                              cmd_o
);

  localparam int EW = ((COORD_BITS > SCR_W) ? COORD_BITS : SCR_W) + 2;

  function automatic coord_t clamp_coord(input logic signed [EW-1:0] v, input coord_t lim);
    logic signed [EW-1:0] lim_s;
    lim_s = $signed({{(EW-SCR_W){1'b0}}, lim});
    if (v[EW-1]) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end
    return v[SCR_W-1:0];
  endfunction

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_step_q;
  logic                 s1_kill_q;
  coord_t               s1_xb_q, s1_xe_q, s1_yb_q, s1_ye_q;
  color_t               s1_color_q;
  logic                 s1_filled_q;
  logic                 s2_valid_q, s2_valid_d;
  cmd_t                 s2_cmd_q, s2_cmd_d;
  logic                 s2_free;
  logic                 in_take;
  logic signed [EW-1:0] x_ext, y_ext, w_ext, h_ext, xe_sum, ye_sum;
  logic                 kill_s1;
  logic                 empty_s2;
  logic [2*SCR_W-1:0]   row_prod;

  assign s2_free    = !s2_valid_q || cmd_ready_i;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_take    = in_valid_i && in_ready_o;

  assign s1_valid_d = in_ready_o ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_free ? s1_valid_q : s2_valid_q;

  assign x_ext  = $signed({{(EW-COORD_BITS){origin_x_i[COORD_BITS-1]}}, origin_x_i});
  assign y_ext  = $signed({{(EW-COORD_BITS){origin_y_i[COORD_BITS-1]}}, origin_y_i});
  assign w_ext  = $signed({{(EW-COORD_BITS){size_w_i[COORD_BITS-1]}}, size_w_i});
  assign h_ext  = $signed({{(EW-COORD_BITS){size_h_i[COORD_BITS-1]}}, size_h_i});
  assign xe_sum = x_ext + w_ext;
  assign ye_sum = y_ext + h_ext;

  assign kill_s1 = (cfg_i.transp_en && (fill_color_i == cfg_i.transp_color)) || cfg_i.mode[1];

  assign empty_s2 = (s1_xb_q >= s1_xe_q) || (s1_yb_q >= s1_ye_q);
  assign row_prod = {{SCR_W{1'b0}}, s1_yb_q} * {{SCR_W{1'b0}}, cfg_i.eff_width};

  always_comb begin
    s2_cmd_d          = s2_cmd_q;
    s2_cmd_d.x_begin  = s1_xb_q;
    s2_cmd_d.x_end    = s1_xe_q;
    s2_cmd_d.y_begin  = s1_yb_q;
    s2_cmd_d.y_end    = s1_ye_q;
    s2_cmd_d.row_base = row_prod[ADDR_W-1:0];
    s2_cmd_d.color    = s1_color_q;
    s2_cmd_d.filled   = s1_filled_q;
    if (s1_step_q) begin
      s2_cmd_d.kind = CMD_STEP;
    end else if (s1_kill_q || empty_s2) begin
      s2_cmd_d.kind = CMD_STOP;
    end else begin
      s2_cmd_d.kind = CMD_START;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_step_q   <= operation_i;
      s1_kill_q   <= kill_s1;
      s1_xb_q     <= clamp_coord(x_ext, cfg_i.eff_width);
      s1_xe_q     <= clamp_coord(xe_sum, cfg_i.eff_width);
      s1_yb_q     <= clamp_coord(y_ext, cfg_i.eff_height);
      s1_ye_q     <= clamp_coord(ye_sum, cfg_i.eff_height);
      s1_color_q  <= fill_color_i;
      s1_filled_q <= filled_i;
    end
    if (s2_free && s1_valid_q) begin
      s2_cmd_q <= s2_cmd_d;
    end
  end

  assign cmd_valid_o = s2_valid_q;
  assign cmd_o       = s2_cmd_q;

endmodule

`default_nettype wire

FILE: src/rfr_fifo.sv
// Short command queue between the front end and the pixel walker.
`default_nettype none

module rfr_fifo import rfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire cmd_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/rfr_back.sv
// Pixel walker: holds the clipped job, emits at most one framebuffer write per step.
`default_nettype none

module rfr_back import rfr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 cmd_valid_i,
  output logic                      cmd_ready_o,
  input  wire cmd_t                 cmd_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output addr_t                     out_addr_o,
  output color_t                    out_data_o,
  output logic [MASK_W-1:0]         out_mask_o,
  output logic                      out_last_o
);

  logic              busy_q, busy_d;
  coord_t            cur_x_q, cur_x_d;
  coord_t            cur_y_q, cur_y_d;
  coord_t            cxb_q, cxb_d, cxe_q, cxe_d;
  coord_t            cyb_q, cyb_d, cye_q, cye_d;
  addr_t             row_base_q, row_base_d;
  color_t            color_q, color_d;
  logic              filled_q, filled_d;
  logic              out_valid_q, out_valid_d;
  addr_t             out_addr_q, addr_c;
  color_t            out_data_q, data_c;
  logic [MASK_W-1:0] out_mask_q, mask_c;
  logic              out_last_q;
  logic              pop;
  logic              draw;
  addr_t             lin;
  logic [SCR_W:0]    x_inc, y_inc;
  logic              fin, more_x, inner_row;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign draw        = pop && (cmd_i.kind == CMD_STEP) && busy_q && !cfg_i.mode[1];

  assign lin       = row_base_q + {{(ADDR_W-SCR_W){1'b0}}, cur_x_q};
  assign x_inc     = {1'b0, cur_x_q} + 1'b1;
  assign y_inc     = {1'b0, cur_y_q} + 1'b1;
  assign fin       = (x_inc == {1'b0, cxe_q}) && (y_inc == {1'b0, cye_q});
  assign more_x    = x_inc < {1'b0, cxe_q};
  assign inner_row = (cur_y_q != cyb_q) && (y_inc != {1'b0, cye_q});

  always_comb begin
    if (cfg_i.mode == PIXEL_MODE_BYTE) begin
      addr_c = lin;
      data_c = color_q & BYTE_FULL;
      mask_c = LANE_BOTH;
    end else begin
      addr_c = lin >> 1;
      if (cur_x_q[0]) begin
        data_c = (color_q << 4) & NIBBLE_HIGH;
        mask_c = LANE_HIGH;
      end else begin
        data_c = color_q & NIBBLE_LOW;
        mask_c = LANE_LOW;
      end
    end
  end

  always_comb begin
    busy_d     = busy_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cxb_d      = cxb_q;
    cxe_d      = cxe_q;
    cyb_d      = cyb_q;
    cye_d      = cye_q;
    row_base_d = row_base_q;
    color_d    = color_q;
    filled_d   = filled_q;
    if (pop) begin
      case (cmd_i.kind)
        CMD_START: begin
          busy_d     = 1'b1;
          cxb_d      = cmd_i.x_begin;
          cxe_d      = cmd_i.x_end;
          cyb_d      = cmd_i.y_begin;
          cye_d      = cmd_i.y_end;
          cur_x_d    = cmd_i.x_begin;
          cur_y_d    = cmd_i.y_begin;
          row_base_d = cmd_i.row_base;
          color_d    = cmd_i.color;
          filled_d   = cmd_i.filled;
        end
        CMD_STOP: begin
          busy_d = 1'b0;
        end
        CMD_STEP: begin
          if (busy_q) begin
            if (cfg_i.mode[1] || fin) begin
              busy_d = 1'b0;
            end else if (more_x) begin
              if (!filled_q && inner_row) begin
                cur_x_d = cxe_q - 1'b1;
              end else begin
                cur_x_d = x_inc[SCR_W-1:0];
              end
            end else begin
              cur_x_d    = cxb_q;
              cur_y_d    = y_inc[SCR_W-1:0];
              row_base_d = row_base_q + {{(ADDR_W-SCR_W){1'b0}}, cfg_i.eff_width};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (draw) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cxb_q       <= '0;
      cxe_q       <= '0;
      cyb_q       <= '0;
      cye_q       <= '0;
      row_base_q  <= '0;
      color_q     <= '0;
      filled_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      cxb_q       <= cxb_d;
      cxe_q       <= cxe_d;
      cyb_q       <= cyb_d;
      cye_q       <= cye_d;
      row_base_q  <= row_base_d;
      color_q     <= color_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw) begin
      out_addr_q <= addr_c;
      out_data_q <= data_c;
      out_mask_q <= mask_c;
      out_last_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_data_o  = out_data_q;
  assign out_mask_o  = out_mask_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

FILE: src/rect_fill_raster.sv
// Top level of the clipped rectangle fill rasterizer.
//
// Items enter on the s_axis channel. tuser carries the operation: 0 starts a
// rectangle, 1 asks for the next pixel write. A start is clipped to the
// configured screen and loaded into the pixel walker; each step then yields
// at most one framebuffer write on the m_axis channel, with tlast on the final
// pixel of the rectangle. Outline jobs skip interior pixels.
// Throughput is one item per cycle while the queue has room: the front end
// clips and multiplies the row base in two register stages, the walker forms
// one write per cycle while m_axis is not stalled. A four-entry command queue
// decouples them, so s_axis keeps accepting items while m_axis is stalled until
// the queue fills; a stalled write holds in the output register. Reset clears
// the job, the queue and the configuration registers to their defaults.
// Configuration writes through cfg_we_i are expected only while no item is in
// flight.
`default_nettype none

module rect_fill_raster import rfr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COORD_BITS = 12
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                          cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]                         cfg_data_i,
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  // origin_x, origin_y, size_w, size_h, fill_color, filled, zero padding
  input  wire logic [((4*COORD_BITS+COLOR_W+1+7)/8)*8-1:0]   s_axis_tdata,
  // operation
  input  wire logic                                          s_axis_tuser,
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  // byte_address, write_data, lane_mask, zero padding
  output logic [OUT_TDATA_W-1:0]                             m_axis_tdata,
  output logic                                               m_axis_tlast
);

  localparam int MaxWClip = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int MaxHClip = (MAX_HEIGHT > 2047) ? 2047 : MAX_HEIGHT;
  localparam coord_t MaxW = MaxWClip[SCR_W-1:0];
  localparam coord_t MaxH = MaxHClip[SCR_W-1:0];

  coord_t              width_q;
  coord_t              height_q;
  logic [MODE_W-1:0]   mode_q;
  color_t              tcolor_q;
  logic                ten_q;
  cfg_t                cfg;
  logic                cmd_valid, cmd_ready;
  cmd_t                cmd;
  logic                q_valid, q_pop;
  cmd_t                q_data;
  addr_t               out_addr;
  color_t              out_data;
  logic [MASK_W-1:0]   out_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= coord_t'(1);
      height_q <= coord_t'(1);
      mode_q   <= PIXEL_MODE_PACKED;
      tcolor_q <= BYTE_FULL;
      ten_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        REG_TCOLOR: tcolor_q <= cfg_data_i[COLOR_W-1:0];
        REG_TEN:    ten_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.eff_width    = (width_q > MaxW) ? MaxW : width_q;
    cfg.eff_height   = (height_q > MaxH) ? MaxH : height_q;
    cfg.mode         = mode_q;
    cfg.transp_color = tcolor_q;
    cfg.transp_en    = ten_q;
  end

  rfr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .operation_i (s_axis_tuser),
    .origin_x_i  ($signed(s_axis_tdata[COORD_BITS-1:0])),
    .origin_y_i  ($signed(s_axis_tdata[2*COORD_BITS-1:COORD_BITS])),
    .size_w_i    ($signed(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .size_h_i    ($signed(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .fill_color_i(s_axis_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .filled_i    (s_axis_tdata[4*COORD_BITS+COLOR_W]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rfr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(cmd_valid),
    .push_ready_o(cmd_ready),
    .push_data_i (cmd),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  rfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_pop),
    .cmd_i      (q_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_addr_o (out_addr),
    .out_data_o (out_data),
    .out_mask_o (out_mask),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-ADDR_W-COLOR_W-MASK_W){1'b0}},
                         out_mask, out_data, out_addr};

endmodule

`default_nettype wire

FILE: src/rfr_checker.sv
// Port-level checks on the write channel of the rasterizer, bound to the top level.
`default_nettype none

module rfr_checker import rfr_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast
);

  logic [MASK_W-1:0] mask;
  color_t            data;

  assign mask = m_axis_tdata[OUT_MASK_LSB +: MASK_W];
  assign data = m_axis_tdata[OUT_DATA_LSB +: COLOR_W];

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("write transfer dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("write payload changed while stalled");

  a_lane_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (mask == LANE_BOTH) ||
                      (mask == LANE_LOW && (data & NIBBLE_HIGH) == '0) ||
                      (mask == LANE_HIGH && (data & NIBBLE_LOW) == '0))
    else $error("lane mask and write data disagree");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("write offered right after reset");

endmodule

bind rect_fill_raster rfr_checker u_rfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

FILE: tb/rect_fill_raster_tb.sv
// Self-checking testbench for the clipped rectangle fill rasterizer.
`timescale 1ns / 1ps

module rect_fill_raster_tb import rfr_pkg::*; ();

  localparam int COORD_W        = 12;
  localparam int SCREEN_MAX_W   = 1024;
  localparam int SCREEN_MAX_H   = 1024;
  localparam int IN_TDATA_W     = ((4*COORD_W + COLOR_W + 1 + 7)/8)*8;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

  typedef struct {
    logic                      op;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] sw;
    logic signed [COORD_W-1:0] sh;
    color_t                    color;
    logic                      filled;
  } draw_cmd_t;

  typedef struct {
    addr_t             addr;
    color_t            data;
    logic [MASK_W-1:0] mask;
    logic              last;
  } fb_write_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;

  rect_fill_raster #(
    .MAX_WIDTH (SCREEN_MAX_W),
    .MAX_HEIGHT(SCREEN_MAX_H),
    .COORD_BITS(COORD_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and walker state of the expected behavior.
  logic [SCR_W-1:0]  disp_width = 11'd1;
  logic [SCR_W-1:0]  disp_height = 11'd1;
  logic [MODE_W-1:0] pix_mode = PIXEL_MODE_PACKED;
  color_t            key_color = 8'hFF;
  logic              key_enable = 1'b1;

  logic   job_busy = 1'b0;
  coord_t col = '0;
  coord_t row = '0;
  coord_t x_lo = '0;
  coord_t x_hi = '0;
  coord_t y_lo = '0;
  coord_t y_hi = '0;
  addr_t  line_base = '0;
  color_t job_color = '0;
  logic   job_filled = 1'b0;

  fb_write_t pending_writes[$];

  int  n_errors = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  int  quiet_cycles = 0;
  bit  hold_on = 1'b0;
  event hold_off_req;

  function automatic int screen_w();
    return (disp_width > SCREEN_MAX_W) ? SCREEN_MAX_W : int'(disp_width);
  endfunction

  function automatic int screen_h();
    return (disp_height > SCREEN_MAX_H) ? SCREEN_MAX_H : int'(disp_height);
  endfunction

  function automatic int clip_edge(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void raster_predict(input draw_cmd_t c);
    int        xb, xe, yb, ye, sw, sh;
    addr_t     lin;
    fb_write_t wr;
    coord_t    nx;
    logic      fin;
    logic      inner;
    sw = screen_w();
    sh = screen_h();
    if (c.op == OP_START) begin
      xb = clip_edge(int'(c.ox), sw);
      xe = clip_edge(int'(c.ox) + int'(c.sw), sw);
      yb = clip_edge(int'(c.oy), sh);
      ye = clip_edge(int'(c.oy) + int'(c.sh), sh);
      job_busy = 1'b0;
      if (key_enable && c.color == key_color) return;
      if (pix_mode != PIXEL_MODE_PACKED && pix_mode != PIXEL_MODE_BYTE) return;
      if (xb >= xe || yb >= ye) return;
      x_lo = coord_t'(xb);
      x_hi = coord_t'(xe);
      y_lo = coord_t'(yb);
      y_hi = coord_t'(ye);
      col = coord_t'(xb);
      row = coord_t'(yb);
      line_base = addr_t'(yb * sw);
      job_color = c.color;
      job_filled = c.filled;
      job_busy = 1'b1;
      return;
    end
    if (!job_busy) return;
    if (pix_mode != PIXEL_MODE_PACKED && pix_mode != PIXEL_MODE_BYTE) begin
      job_busy = 1'b0;
      return;
    end
    lin = line_base + addr_t'(col);
    if (pix_mode == PIXEL_MODE_BYTE) begin
      wr.addr = lin;
      wr.data = job_color;
      wr.mask = LANE_BOTH;
    end else begin
      wr.addr = lin >> 1;
      if (col[0]) begin
        wr.data = (job_color & NIBBLE_LOW) << 4;
        wr.mask = LANE_HIGH;
      end else begin
        wr.data = job_color & NIBBLE_LOW;
        wr.mask = LANE_LOW;
      end
    end
    fin = (col + 1 == x_hi) && (row + 1 == y_hi);
    wr.last = fin;
    pending_writes.push_back(wr);
    if (fin) begin
      job_busy = 1'b0;
    end else if (col + 1 < x_hi) begin
      nx = col + 1'b1;
      inner = (row != y_lo) && (row + 1 != y_hi);
      if (!job_filled && inner) nx = x_hi - 1'b1;
      col = nx;
    end else begin
      col = x_lo;
      row = row + 1'b1;
      line_base = line_base + addr_t'(sw);
    end
  endfunction

  function automatic draw_cmd_t start_cmd(input int x, input int y, input int w, input int h,
                                          input color_t color, input logic filled);
    draw_cmd_t c;
    c.op = OP_START;
    c.ox = COORD_W'(x);
    c.oy = COORD_W'(y);
    c.sw = COORD_W'(w);
    c.sh = COORD_W'(h);
    c.color = color;
    c.filled = filled;
    return c;
  endfunction

  // Steps carry random geometry, which the block must ignore.
  function automatic draw_cmd_t step_cmd();
    draw_cmd_t c;
    c.op = OP_STEP;
    c.ox = COORD_W'($urandom);
    c.oy = COORD_W'($urandom);
    c.sw = COORD_W'($urandom);
    c.sh = COORD_W'($urandom);
    c.color = color_t'($urandom);
    c.filled = 1'($urandom);
    return c;
  endfunction

  task automatic send_cmd(input draw_cmd_t c);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.op;
    s_axis_tdata  <= IN_TDATA_W'({c.filled, c.color, c.sh, c.sw, c.oy, c.ox});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    raster_predict(c);
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_writes.size() != 0);
  endtask

  // Starts and idle steps give no write, so they may still be in flight.
  task automatic wait_idle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_screen(input int w, input int h, input logic [MODE_W-1:0] mode,
                            input color_t tcolor, input logic ten);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0]  regs[5];
    wait_idle();
    vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(mode), CFG_DATA_W'(tcolor),
             CFG_DATA_W'(ten)};
    regs = '{REG_WIDTH, REG_HEIGHT, REG_MODE, REG_TCOLOR, REG_TEN};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    disp_width  = vals[0];
    disp_height = vals[1];
    pix_mode    = mode;
    key_color   = tcolor;
    key_enable  = ten;
  endtask

  task automatic random_screen();
    int w, h;
    logic [MODE_W-1:0] mode;
    case ($urandom_range(0, 9))
      0: w = SCREEN_MAX_W;
      1: w = 2047;
      2: w = $urandom_range(1, 2047);
      default: w = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 9))
      0: h = SCREEN_MAX_H;
      1: h = 2047;
      2: h = $urandom_range(1, 2047);
      default: h = $urandom_range(1, 24);
    endcase
    mode = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(2, 3))
                                       : MODE_W'($urandom_range(0, 1));
    set_screen(w, h, mode, color_t'($urandom), 1'($urandom));
  endtask

  task automatic test_directed_corners();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // Defaults after reset: one pixel screen, 4bpp, color 255 transparent.
    send_cmd(start_cmd(0, 0, 1, 1, 8'hFF, 1'b1));
    send_cmd(step_cmd());
    send_cmd(start_cmd(0, 0, 1, 1, 8'h3C, 1'b1));
    send_cmd(step_cmd());
    send_cmd(step_cmd());
    // Oversized screen saturates; the corner reaches the top byte address.
    set_screen(2047, 2047, PIXEL_MODE_BYTE, 8'h00, 1'b0);
    send_cmd(start_cmd(1022, 1022, 2047, 2047, 8'hFF, 1'b1));
    repeat (4) send_cmd(step_cmd());
    send_cmd(start_cmd(-2048, -2048, -2048, -2048, 8'h81, 1'b0));
    send_cmd(start_cmd(2047, 2047, 1, 1, 8'h81, 1'b1));
    send_cmd(step_cmd());
    // Outline clipped at the left edge, both nibble lanes.
    set_screen(5, 4, PIXEL_MODE_PACKED, 8'h00, 1'b1);
    send_cmd(start_cmd(-1, 0, 6, 4, 8'hA5, 1'b0));
    repeat (14) send_cmd(step_cmd());
  endtask

  task automatic test_config_mid_job();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_screen(8, 6, PIXEL_MODE_PACKED, 8'h00, 1'b0);
    send_cmd(start_cmd(0, 0, 8, 6, 8'h5A, 1'b1));
    repeat (3) send_cmd(step_cmd());
    // An ignored start still ends the running job.
    send_cmd(start_cmd(3, 3, 0, 2, 8'h5A, 1'b1));
    send_cmd(step_cmd());
    send_cmd(start_cmd(1, 1, 7, 5, 8'hC3, 1'b0));
    repeat (3) send_cmd(step_cmd());
    set_screen(12, 6, PIXEL_MODE_BYTE, 8'hC3, 1'b0);
    repeat (6) send_cmd(step_cmd());
    set_screen(12, 6, MODE_NONE, 8'hC3, 1'b1);
    send_cmd(step_cmd());
    set_screen(12, 6, PIXEL_MODE_PACKED, 8'hC3, 1'b1);
    send_cmd(step_cmd());
    send_cmd(start_cmd(0, 0, 4, 4, 8'hC3, 1'b1));
    send_cmd(step_cmd());
    set_screen(0, 0, PIXEL_MODE_PACKED, 8'h00, 1'b0);
    send_cmd(start_cmd(0, 0, 5, 5, 8'h11, 1'b1));
    send_cmd(step_cmd());
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    set_screen(64, 32, PIXEL_MODE_BYTE, 8'h00, 1'b0);
    send_cmd(start_cmd(0, 0, 64, 32, 8'h77, 1'b1));
    -> hold_off_req;
    repeat (40) send_cmd(step_cmd());
    pause_until_drained();
    snk_stall_pct = 78;
    repeat (20) send_cmd(step_cmd());
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
    int        sent, since_cfg, steps, sw, sh;
    color_t    color;
    draw_cmd_t c;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    sent      = 0;
    since_cfg = 50;
    while (sent < n_items) begin
      if (since_cfg >= 50) begin
        random_screen();
        since_cfg = 0;
      end
      if ($urandom_range(99) < 15) begin
        c = step_cmd();
        c.op = 1'($urandom);
        send_cmd(c);
        sent++;
        since_cfg++;
      end else begin
        sw = screen_w();
        sh = screen_h();
        color = ($urandom_range(0, 9) == 0) ? key_color : color_t'($urandom);
        send_cmd(start_cmd(int'($urandom_range(0, sw + 5)) - 3,
                           int'($urandom_range(0, sh + 5)) - 3,
                           int'($urandom_range(0, 12)) - 2,
                           int'($urandom_range(0, 10)) - 2,
                           color, 1'($urandom)));
        steps = 0;
        while (job_busy && steps < 48) begin
          send_cmd(step_cmd());
          steps++;
        end
        repeat ($urandom_range(0, 1)) begin
          send_cmd(step_cmd());
          steps++;
        end
        sent      += steps + 1;
        since_cfg += steps + 1;
      end
      if ($urandom_range(99) < 3) pause_until_drained();
    end
  endtask

  always begin
    @(hold_off_req);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    fb_write_t got;
    fb_write_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.addr = m_axis_tdata[OUT_ADDR_LSB +: ADDR_W];
      got.data = m_axis_tdata[OUT_DATA_LSB +: COLOR_W];
      got.mask = m_axis_tdata[OUT_MASK_LSB +: MASK_W];
      got.last = m_axis_tlast;
      if (pending_writes.size() == 0) begin
        $error("write with nothing expected: byte_address %0h", got.addr);
        n_errors++;
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr) begin
          $error("byte_address: expected %0h, got %0h", want.addr, got.addr);
          n_errors++;
        end
        if (got.data !== want.data) begin
          $error("write_data: expected %0h, got %0h", want.data, got.data);
          n_errors++;
        end
        if (got.mask !== want.mask) begin
          $error("lane_mask: expected %0d, got %0d", want.mask, got.mask);
          n_errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          n_errors++;
        end
      end
    end
    m_axis_tready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[rect_fill_raster] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_config_mid_job();
    test_backpressure();
    test_random_traffic(135, 0, 0);
    test_random_traffic(135, 78, 0);
    test_random_traffic(135, 0, 78);
    test_random_traffic(135, 10, 10);
    wait_idle();
    if (n_errors == 0) begin
      $display("[rect_fill_raster] OK");
    end else begin
      $display("[rect_fill_raster] ERROR");
    end
    $finish;
  end

endmodule
